// ===== sv/dfia_pkg.sv =====
// Package: shared types, codes and constants of the deferred-free index allocator.
package dfia_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int STAT_W  = 2;

    // Shared ring: 16 slots, pointers count modulo 32
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = 4;
    localparam int PTR_W      = 5;

    // Default heap size
    localparam int HEAP_ENTRIES_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EOF   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_RING_FULL = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] index_in;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [IDX_W-1:0]  index_out;
        logic [STAT_W-1:0] status;
        logic              can_allocate;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted transaction
        logic exec;   // apply it to pointers, ring and result register
    } t_dp_cmd;

endpackage

// ===== sv/dfia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dfia_ctrl.sv =====
// Controller: accepts a transaction, runs the execute state, strobes the result.
module dfia_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_valid,
    output dfia_pkg::t_dp_cmd o_cmd
);
    import dfia_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_valid, n_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy       = (r_state == S_EXEC);
    assign o_valid    = r_valid;
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

    // A result strobe follows the execute state
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without execute cycle");

    // An accepted transaction enters the execute cycle
    a_load_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> busy)
        else $error("accepted transaction without execute cycle");

    // Execute is never extended: busy is low in the cycle after it is high
    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

endmodule

// ===== sv/dfia_dp.sv =====
// Datapath: fresh counter, ring pointers, recycle ring and result register.
module dfia_dp #(
    parameter int HEAP_ENTRIES = dfia_pkg::HEAP_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dfia_pkg::t_dp_cmd i_cmd,
    input  dfia_pkg::t_in     i_item,
    output dfia_pkg::t_out    o_result
);
    import dfia_pkg::*;

    localparam int CNT_W = $clog2(HEAP_ENTRIES + 1);
    localparam logic [CNT_W-1:0] HEAP_CNT = CNT_W'(HEAP_ENTRIES);
    localparam logic [IDX_W-1:0] HEAP_IDX = IDX_W'(HEAP_ENTRIES);
    localparam logic [PTR_W-1:0] RING_FULL_OCC = PTR_W'(RING_DEPTH);

    t_in              r_item;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_split, n_split;
    logic [PTR_W-1:0] r_tail, n_tail;
    t_out             r_out, n_out;

    logic [IDX_W-1:0] ram_rdata;
    logic             ram_we;
    logic [PTR_W-1:0] occupancy;
    logic             free_avail;

    // Ring storage: written at tail, read at head
    dfia_ram #(
        .WIDTH (IDX_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail[SLOT_W-1:0]),
        .i_wdata (r_item.index_in),
        .i_raddr (r_head[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign occupancy  = r_tail - r_head;
    assign free_avail = (r_head != r_split);

    // Command decode and pointer update
    always_comb begin
        n_fresh = r_fresh;
        n_head  = r_head;
        n_split = r_split;
        n_tail  = r_tail;
        ram_we  = 1'b0;
        n_out.index_out = '0;
        n_out.status    = ST_OK;
        unique case (r_item.command)
            CMD_ALLOC: begin
                if (free_avail) begin
                    n_out.index_out = ram_rdata;
                    n_head = r_head + PTR_W'(1);
                end else if (r_fresh < HEAP_CNT) begin
                    n_out.index_out = IDX_W'(r_fresh);
                    n_fresh = r_fresh + CNT_W'(1);
                end else begin
                    n_out.status = ST_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                if (r_item.index_in >= HEAP_IDX) begin
                    n_out.status = ST_RANGE;
                end else if (occupancy == RING_FULL_OCC) begin
                    n_out.status = ST_RING_FULL;
                end else begin
                    ram_we = i_cmd.exec;
                    n_tail = r_tail + PTR_W'(1);
                end
            end
            CMD_EOF: begin
                n_split = r_tail;
            end
            default: begin
                // unused command: no effect
            end
        endcase
        n_out.can_allocate = (n_head != n_split) || (n_fresh < HEAP_CNT);
    end

    // Control state: fresh counter and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= '0;
            r_head  <= '0;
            r_split <= '0;
            r_tail  <= '0;
        end else if (i_cmd.exec) begin
            r_fresh <= n_fresh;
            r_head  <= n_head;
            r_split <= n_split;
            r_tail  <= n_tail;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= RING_FULL_OCC)
        else $error("ring holds more than its depth");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_split - r_head) <= occupancy)
        else $error("split pointer outside head..tail");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= HEAP_CNT)
        else $error("fresh counter beyond heap size");

endmodule

// ===== sv/deferred_free_index_allocator.sv =====
// Top level: deferred-free slot index allocator over a fixed heap.
// Each accepted transaction is applied in the execute state; its result and strobe are registered.
// A new transaction is accepted only while busy is low; busy is high for the one execute cycle,
// in which the registered ring read at the head pointer becomes usable.
// The receiver cannot stall: each result is shown for exactly one cycle on o_valid.
// Synchronous active-low reset empties both queues and zeroes the fresh counter.
module deferred_free_index_allocator #(
    parameter int HEAP_ENTRIES = dfia_pkg::HEAP_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dfia_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_valid,
    output dfia_pkg::t_out o_result
);
    import dfia_pkg::*;

    t_dp_cmd dp_cmd;

    dfia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    dfia_dp #(
        .HEAP_ENTRIES (HEAP_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

// ===== bench/dfia_result_check.sv =====
// Result checker: predicts allocator responses from accepted requests and compares them.
module dfia_result_check #(
    parameter int HEAP_ENTRIES = dfia_pkg::HEAP_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  dfia_pkg::t_in  i_item,
    input  logic           i_valid,
    input  dfia_pkg::t_out i_result,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dfia_pkg::*;

    // Predicted allocator state
    logic [8:0]       fresh_next;
    logic [IDX_W-1:0] slot_store [RING_DEPTH];
    logic [PTR_W-1:0] head_ptr;
    logic [PTR_W-1:0] split_ptr;
    logic [PTR_W-1:0] tail_ptr;

    t_out expected_q [$];
    int   mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    // Apply one request to the predicted state, return the response it gives
    function automatic t_out serve_request(input t_in req);
        t_out             res;
        logic [PTR_W-1:0] fill;
        res  = '0;
        fill = tail_ptr - head_ptr;
        case (req.command)
            CMD_ALLOC: begin
                if (head_ptr != split_ptr) begin
                    // oldest recycled index first
                    res.index_out = slot_store[head_ptr[SLOT_W-1:0]];
                    head_ptr      = head_ptr + 1'b1;
                end else if (fresh_next < HEAP_ENTRIES) begin
                    res.index_out = fresh_next[IDX_W-1:0];
                    fresh_next    = fresh_next + 1'b1;
                end else begin
                    res.status = ST_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                if (req.index_in >= HEAP_ENTRIES) begin
                    res.status = ST_RANGE;
                end else if (fill == RING_DEPTH) begin
                    res.status = ST_RING_FULL;
                end else begin
                    slot_store[tail_ptr[SLOT_W-1:0]] = req.index_in;
                    tail_ptr = tail_ptr + 1'b1;
                end
            end
            CMD_EOF: begin
                // pending frees become reusable
                split_ptr = tail_ptr;
            end
            default: ;
        endcase
        res.can_allocate = (head_ptr != split_ptr) || (fresh_next < HEAP_ENTRIES);
        return res;
    endfunction

    // Compare each result strobe, then predict any transaction accepted at this edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            fresh_next = '0;
            head_ptr   = '0;
            split_ptr  = '0;
            tail_ptr   = '0;
            expected_q.delete();
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with no transaction outstanding: %p", i_result);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.index_out !== want.index_out) begin
                        $error("index_out: expected %0d, got %0d",
                               want.index_out, i_result.index_out);
                        mismatches++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_result.status);
                        mismatches++;
                    end
                    if (i_result.can_allocate !== want.can_allocate) begin
                        $error("can_allocate: expected %0b, got %0b",
                               want.can_allocate, i_result.can_allocate);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(serve_request(i_item));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/deferred_free_index_allocator_test.sv =====
// Testbench top: drives allocator requests, watches for hangs and reports the verdict.
module deferred_free_index_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dfia_pkg::*;

    localparam int HEAP           = HEAP_ENTRIES_DEF;
    localparam int ITEM_TARGET    = 850;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_GAP        = 13;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    int fail_count;
    int pending_results;
    int useful_sent = 0;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    deferred_free_index_allocator #(
        .HEAP_ENTRIES(HEAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    dfia_result_check #(
        .HEAP_ENTRIES(HEAP)
    ) u_alloc_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // Send one request after a random gap; returns at the accepting edge
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= {cmd, idx};
        do @(posedge i_clk); while (busy);
        if (cmd != CMD_NOP && !(cmd == CMD_FREE && idx >= HEAP)) useful_sent++;
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // Hang detection: cycles with neither an accepted request nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("deferred_free_index_allocator: mismatch");
            $finish;
        end
    end

    initial begin
        int kind;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh indices up to exhaustion
        repeat (HEAP + 1) issue(CMD_ALLOC, 8'h00);
        // range limits, double free, pending not yet reusable
        issue(CMD_FREE, 8'(HEAP));
        issue(CMD_FREE, 8'hFF);
        issue(CMD_FREE, 8'h00);
        issue(CMD_FREE, 8'(HEAP - 1));
        issue(CMD_FREE, 8'h00);
        issue(CMD_ALLOC, 8'hFF);
        issue(CMD_EOF, 8'h00);
        // recycled in free order, last one empties the free queue
        repeat (3) issue(CMD_ALLOC, 8'h5A);
        issue(CMD_NOP, 8'hFF);
        issue(CMD_EOF, 8'hA5);
        wait_drained();

        // Random frames with some drains, floods and raw noise
        while (useful_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(3, 0) == 0);
            kind    = $urandom_range(99, 0);
            if (kind < 50) begin
                // typical frame: allocations, frees, end of frame
                n = $urandom_range(6, 0);
                repeat (n) issue(CMD_ALLOC, 8'($urandom_range(255, 0)));
                n = $urandom_range(8, 0);
                repeat (n) issue(CMD_FREE, 8'($urandom_range(HEAP - 1, 0)));
                issue(CMD_EOF, 8'($urandom_range(255, 0)));
            end else if (kind < 65) begin
                // allocation run, usually into exhaustion
                n = $urandom_range(20, 1);
                repeat (n) issue(CMD_ALLOC, 8'($urandom_range(255, 0)));
            end else if (kind < 80) begin
                // free burst, usually into a full ring
                n = $urandom_range(20, 8);
                repeat (n) issue(CMD_FREE, 8'($urandom_range(HEAP - 1, 0)));
                if ($urandom_range(1, 0)) issue(CMD_EOF, 8'($urandom_range(255, 0)));
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) issue(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
            end
            if ($urandom_range(29, 0) == 0) wait_drained();
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("deferred_free_index_allocator: match");
        end else begin
            $display("deferred_free_index_allocator: mismatch");
        end
        $finish;
    end

endmodule
